>>> src/brfw_pkg.sv
// Package for the byte ring FIFO with word push.
// Holds the sequencer state type, item mode codes and result status codes.
// No dependencies.
package brfw_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PUSH,
    ST_POP_RD,
    ST_POP_OUT
  } state_t;

  localparam logic [1:0] MODE_PUSH  = 2'd0;
  localparam logic [1:0] MODE_POP   = 2'd1;
  localparam logic [1:0] MODE_END   = 2'd2;
  localparam logic [1:0] MODE_SPARE = 2'd3;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_NO_ROOM = 2'd1;
  localparam logic [1:0] STAT_WAIT    = 2'd2;
  localparam logic [1:0] STAT_EOS     = 2'd3;

  localparam logic [2:0] MAX_BYTES = 3'd4;
  localparam logic [7:0] BYTE_MASK = 8'hff;

endpackage

>>> src/byte_ring_fifo_word_push.sv
// Top level of the byte ring FIFO with word push, pop and end-of-stream marks.
// Depends on brfw_pkg and brfw_ram.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall   | mode, word_value, byte_count, big_endian
//   out_    | output    | out_valid/out_stall | data_byte, status, last_of_run, fill_level
//
// A push transfers the item, then writes one byte a cycle through the single write
// port of the byte store.
// A pop transfers the item and issues the first read of the store in ST_POP_RD; then
// one byte result leaves per cycle unless the output stalls, while reads overlap.
// Every other item loads its single result at the edge that takes it and leaves the
// sequencer in ST_IDLE for the next item.
// Reset clears the indices, the fill count and the marks; the store needs no clear.
// A stalled output register holds the intake and the pop output; push writes go on.
module byte_ring_fifo_word_push #(
  parameter int DEPTH = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_mode,
  input  logic [31:0] in_word_value,
  input  logic [2:0]  in_byte_count,
  input  logic        in_big_endian,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_data_byte,
  output logic [1:0]  out_status,
  output logic        out_last_of_run,
  output logic [10:0] out_fill_level
);

  import brfw_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = CW + 3;

  function automatic logic [AW-1:0] next_ptr(input logic [AW-1:0] p);
    if (p == AW'(DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  function automatic logic [10:0] fill_of(input logic [CW-1:0] c);
    logic [CW+10:0] t;
    t = {11'b0, c};
    return t[10:0];
  endfunction

  state_t state_r, state_nxt;

  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;
  logic          ended_r;
  logic [2:0]    left_r;
  logic [31:0]   push_bytes_r;

  logic        out_valid_r;
  logic [7:0]  out_data_r;
  logic [1:0]  out_status_r;
  logic        out_last_r;
  logic [10:0] out_fill_r;

  // Sequencer decisions
  logic        out_free, acc;
  logic [2:0]  cnt3;
  logic        push_fit, pop_short;
  logic        go_push, go_pop;
  logic [2:0]  take;
  logic [31:0] ordered;
  logic        out_load;
  logic [7:0]  load_data;
  logic [1:0]  load_status;
  logic        load_last;
  logic [10:0] load_fill;
  logic        wr_en, rd_en;
  logic [7:0]  rd_q;
  logic [1:0]  lane;

  assign out_free  = !out_valid_r || !out_stall;
  // Same condition as an input transfer: the input is open only when idle with a free output register.
  assign acc       = (state_r == ST_IDLE) && in_valid && out_free;
  assign cnt3      = (in_byte_count > MAX_BYTES) ? MAX_BYTES : in_byte_count;
  assign push_fit  = EW'(cnt3) <= EW'(CW'(DEPTH) - cnt_r);
  assign pop_short = EW'(cnt_r) < EW'(cnt3);

  // Reorder the word so that byte i of the push sits at bits [8i+7:8i].
  always_comb begin
    ordered = '0;
    lane    = '0;
    for (int i = 0; i < 4; i++) begin
      lane = in_big_endian ? 2'(cnt3 - 3'(i) - 3'd1) : 2'(i);
      if (3'(i) < cnt3) begin
        ordered[8*i +: 8] = in_word_value[8*lane +: 8] & BYTE_MASK;
      end
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (go_push) begin
          state_nxt = ST_PUSH;
        end else if (go_pop) begin
          state_nxt = ST_POP_RD;
        end
      end
      ST_PUSH: begin
        if (left_r == 3'd1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_POP_RD: begin
        state_nxt = ST_POP_OUT;
      end
      ST_POP_OUT: begin
        if (out_free && left_r == 3'd1) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_stall    = 1'b1;
    go_push     = 1'b0;
    go_pop      = 1'b0;
    take        = cnt3;
    out_load    = 1'b0;
    load_data   = '0;
    load_status = STAT_OK;
    load_last   = 1'b1;
    load_fill   = fill_of(cnt_r);
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = !out_free;
        if (acc) begin
          out_load = 1'b1;
          unique case (in_mode)
            MODE_PUSH: begin
              if (!push_fit) begin
                load_status = STAT_NO_ROOM;
              end else begin
                load_fill = fill_of(cnt_r + CW'(cnt3));
                go_push   = cnt3 != 3'd0;
              end
            end
            MODE_POP: begin
              if (cnt3 == 3'd0) begin
                load_status = STAT_OK;
              end else if (pop_short && !ended_r) begin
                load_status = STAT_WAIT;
              end else if (pop_short && cnt_r == '0) begin
                load_status = STAT_EOS;
              end else begin
                // The byte results follow from the store; none now.
                out_load = 1'b0;
                go_pop   = 1'b1;
                take     = pop_short ? 3'(cnt_r) : cnt3;
              end
            end
            default: begin
              load_status = STAT_OK;
            end
          endcase
        end
      end
      ST_PUSH: begin
        wr_en = 1'b1;
      end
      ST_POP_RD: begin
        rd_en = 1'b1;
      end
      ST_POP_OUT: begin
        out_load  = out_free;
        load_data = rd_q;
        load_last = left_r == 3'd1;
        load_fill = fill_of(cnt_r - 1'b1);
        // Issue the next read while this byte leaves.
        rd_en     = out_free && left_r > 3'd1;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      cnt_r       <= '0;
      ended_r     <= 1'b0;
      left_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == ST_IDLE && acc && in_mode == MODE_END) begin
        ended_r <= 1'b1;
      end
      if (go_push) begin
        cnt_r  <= cnt_r + CW'(cnt3);
        left_r <= cnt3;
      end
      if (go_pop) begin
        left_r <= take;
      end
      if (wr_en) begin
        wr_ptr_r <= next_ptr(wr_ptr_r);
        left_r   <= left_r - 3'd1;
      end
      if (rd_en) begin
        rd_ptr_r <= next_ptr(rd_ptr_r);
      end
      if (state_r == ST_POP_OUT && out_load) begin
        cnt_r  <= cnt_r - 1'b1;
        left_r <= left_r - 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go_push) begin
      push_bytes_r <= ordered;
    end else if (wr_en) begin
      push_bytes_r <= {8'h00, push_bytes_r[31:8]};
    end
    if (out_load) begin
      out_data_r   <= load_data;
      out_status_r <= load_status;
      out_last_r   <= load_last;
      out_fill_r   <= load_fill;
    end
  end

  brfw_ram #(
    .DEPTH(DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_ptr_r),
    .wr_data (push_bytes_r[7:0]),
    .rd_en   (rd_en),
    .rd_addr (rd_ptr_r),
    .rd_q    (rd_q)
  );

  assign out_valid       = out_valid_r;
  assign out_data_byte   = out_data_r;
  assign out_status      = out_status_r;
  assign out_last_of_run = out_last_r;
  assign out_fill_level  = out_fill_r;

  a_cnt_bound : assert property (@(posedge clk) disable iff (!rst_n)
    EW'(cnt_r) <= EW'(DEPTH))
    else $error("fill count exceeds depth");

  a_no_rw_overlap : assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> !rd_en)
    else $error("store read and write in the same cycle");

  a_pop_starts : assert property (@(posedge clk) disable iff (!rst_n)
    go_pop |=> state_r == ST_POP_RD && left_r != 3'd0)
    else $error("pop did not start its first read");

  a_no_overwrite : assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || !out_stall))
    else $error("held result overwritten");

  a_pop_has_bytes : assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_POP_OUT |-> left_r != 3'd0 && cnt_r != '0)
    else $error("pop output with nothing left");

endmodule

>>> src/brfw_ram.sv
// Byte store of the ring FIFO: one write port, one read port, registered read data.
// Stand-alone; the top level sets its depth.
module brfw_ram #(
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_q
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

endmodule

>>> dv/tb_byte_ring_fifo_word_push.sv
// Self-checking testbench for byte_ring_fifo_word_push.
// A behavioral ring model predicts every result, and each result transfer is checked
// field by field. Depends on brfw_pkg and the RTL under src/.
`timescale 1ns / 100ps

module tb_byte_ring_fifo_word_push;
  import brfw_pkg::*;

  localparam int RING_DEPTH = 1024;
  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 12;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [1:0]  status;
    logic        last_of_run;
    logic [10:0] fill_level;
  } fifo_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_mode = MODE_PUSH;
  logic [31:0] in_word_value = '0;
  logic [2:0]  in_byte_count = '0;
  logic        in_big_endian = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_data_byte;
  logic [1:0]  out_status;
  logic        out_last_of_run;
  logic [10:0] out_fill_level;

  // Ring model state.
  logic [7:0]  ring_mem [RING_DEPTH];
  int unsigned wr_ptr = 0;
  int unsigned rd_ptr = 0;
  logic        ring_full = 1'b0;
  logic        stream_ended = 1'b0;

  fifo_result_t pending_results[$];
  int unsigned  error_count = 0;
  int unsigned  cycle_count = 0;
  logic         quiet_traffic = 1'b0;

  byte_ring_fifo_word_push dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_mode         (in_mode),
    .in_word_value   (in_word_value),
    .in_byte_count   (in_byte_count),
    .in_big_endian   (in_big_endian),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data_byte   (out_data_byte),
    .out_status      (out_status),
    .out_last_of_run (out_last_of_run),
    .out_fill_level  (out_fill_level)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= !quiet_traffic && ($urandom_range(0, 99) < 20);
  end

  function automatic int unsigned held_count();
    if (ring_full) return RING_DEPTH;
    return (wr_ptr + RING_DEPTH - rd_ptr) % RING_DEPTH;
  endfunction

  function automatic void queue_result(input logic [7:0] data, input logic [1:0] status,
                                       input logic last);
    fifo_result_t r;
    r.data_byte   = data;
    r.status      = status;
    r.last_of_run = last;
    r.fill_level  = 11'(held_count());
    pending_results.push_back(r);
  endfunction

  // Applies one accepted item to the ring model and queues the results it causes.
  function automatic void ring_apply_item(input logic [1:0] mode, input logic [31:0] word,
                                          input logic [2:0] raw_count, input logic big);
    int unsigned nbytes;
    int unsigned space;
    int unsigned held;
    int unsigned take;
    int unsigned lane;
    nbytes = (raw_count > MAX_BYTES) ? 32'(MAX_BYTES) : 32'(raw_count);
    case (mode)
      MODE_PUSH: begin
        space = RING_DEPTH - held_count();
        if (nbytes > space) begin
          queue_result('0, STAT_NO_ROOM, 1'b1);
        end else begin
          for (int i = 0; i < nbytes; i++) begin
            lane = big ? (nbytes - 1 - i) : i;
            ring_mem[10'(wr_ptr)] = 8'((word >> (8 * lane)) & BYTE_MASK);
            wr_ptr = (wr_ptr + 1) % RING_DEPTH;
          end
          if (nbytes > 0 && nbytes == space) ring_full = 1'b1;
          queue_result('0, STAT_OK, 1'b1);
        end
      end
      MODE_POP: begin
        held = held_count();
        if (nbytes == 0) begin
          queue_result('0, STAT_OK, 1'b1);
        end else if (held < nbytes && !stream_ended) begin
          queue_result('0, STAT_WAIT, 1'b1);
        end else if (held == 0) begin
          queue_result('0, STAT_EOS, 1'b1);
        end else begin
          take = (held < nbytes) ? held : nbytes;
          for (int i = 0; i < take; i++) begin
            logic [7:0] b;
            b = ring_mem[10'(rd_ptr)];
            rd_ptr = (rd_ptr + 1) % RING_DEPTH;
            ring_full = 1'b0;
            queue_result(b, STAT_OK, i + 1 == take);
          end
        end
      end
      default: begin
        // End marks the stream ended; the unused mode leaves everything as it was; both give a plain ok result.
        if (mode == MODE_END) stream_ended = 1'b1;
        queue_result('0, STAT_OK, 1'b1);
      end
    endcase
  endfunction

  // Must be called right after a rising edge.
  task automatic send_item(input logic [1:0] mode, input logic [31:0] word,
                           input logic [2:0] count, input logic big);
    while (!quiet_traffic && $urandom_range(0, 99) < 20) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_mode       <= mode;
    in_word_value <= word;
    in_byte_count <= count;
    in_big_endian <= big;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    ring_apply_item(mode, word, count, big);
  endtask

  task automatic check_field(input string name, input int unsigned expected,
                             input int unsigned actual);
    if (expected != actual) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, expected, actual);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result transfer, actual data %0h status %0d",
                 $time, out_data_byte, out_status);
        error_count++;
      end else begin
        fifo_result_t exp_r;
        exp_r = pending_results.pop_front();
        check_field("data_byte", 32'(exp_r.data_byte), 32'(out_data_byte));
        check_field("status", 32'(exp_r.status), 32'(out_status));
        check_field("last_of_run", 32'(exp_r.last_of_run), 32'(out_last_of_run));
        check_field("fill_level", 32'(exp_r.fill_level), 32'(out_fill_level));
      end
    end
  end

  task automatic test_directed_cases();
    send_item(MODE_POP, 32'h0, 3'd1, 1'b0);          // empty ring, must wait
    send_item(MODE_PUSH, 32'h44332211, 3'd4, 1'b0);
    send_item(MODE_PUSH, 32'h88776655, 3'd4, 1'b1);
    send_item(MODE_PUSH, 32'hffabcdef, 3'd3, 1'b0);
    send_item(MODE_PUSH, 32'h0000a55a, 3'd2, 1'b1);
    send_item(MODE_PUSH, 32'hffffffff, 3'd1, 1'b0);
    send_item(MODE_PUSH, 32'h00000000, 3'd1, 1'b1);
    send_item(MODE_POP, 32'hffffffff, 3'd4, 1'b1);
    send_item(MODE_POP, 32'h0, 3'd7, 1'b0);          // count saturates to four
    send_item(MODE_PUSH, 32'hdeadbeef, 3'd0, 1'b1);  // zero-byte push
    send_item(MODE_POP, 32'h0, 3'd0, 1'b0);          // zero-byte pop
    send_item(MODE_PUSH, 32'hffffffff, 3'd6, 1'b1);
    send_item(MODE_PUSH, 32'h01020304, 3'd5, 1'b0);
    send_item(MODE_SPARE, 32'hffffffff, 3'd7, 1'b1); // unused mode
    send_item(MODE_POP, 32'h0, 3'd3, 1'b0);
    send_item(MODE_POP, 32'h0, 3'd2, 1'b1);
    send_item(MODE_POP, 32'h0, 3'd4, 1'b0);
    send_item(MODE_POP, 32'h0, 3'd4, 1'b0);
    send_item(MODE_POP, 32'h0, 3'd4, 1'b0);          // too few bytes held
    send_item(MODE_POP, 32'h0, 3'd1, 1'b0);
  endtask

  task automatic test_random_traffic(input int n_items, input logic allow_end);
    int unsigned pick;
    for (int k = 0; k < n_items; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45)
        send_item(MODE_PUSH, $urandom(), 3'($urandom_range(1, 4)),
                  1'($urandom_range(0, 1)));
      else if (pick < 85)
        send_item(MODE_POP, $urandom(), 3'($urandom_range(1, 4)),
                  1'($urandom_range(0, 1)));
      else if (pick < 90 && allow_end)
        send_item(MODE_END, $urandom(), 3'($urandom_range(0, 7)),
                  1'($urandom_range(0, 1)));
      else if (pick < 95)
        send_item($urandom_range(0, 1) ? MODE_POP : MODE_PUSH, $urandom(),
                  $urandom_range(0, 1) ? 3'd0 : 3'($urandom_range(5, 7)),
                  1'($urandom_range(0, 1)));
      else
        send_item(MODE_SPARE, $urandom(), 3'($urandom_range(0, 7)),
                  1'($urandom_range(0, 1)));
    end
  endtask

  // Fills the ring to the brim, which also carries the write index across the wrap.
  task automatic test_fill_to_full();
    int unsigned n_sent;
    int unsigned space;
    n_sent = 0;
    quiet_traffic <= 1'b1;
    while (!ring_full) begin
      if (n_sent == 100) quiet_traffic <= 1'b0;
      space = RING_DEPTH - held_count();
      // Close to the brim, the push fits exactly so that the ring ends full.
      if (space < 4)
        send_item(MODE_PUSH, $urandom(), 3'(space), 1'($urandom_range(0, 1)));
      else
        send_item(MODE_PUSH, $urandom(), ($urandom_range(0, 7) == 0)
                  ? 3'($urandom_range(1, 3)) : 3'd4, 1'($urandom_range(0, 1)));
      n_sent++;
    end
    quiet_traffic <= 1'b0;
    repeat (3) send_item(MODE_PUSH, $urandom(), 3'($urandom_range(1, 7)),
                         1'($urandom_range(0, 1)));
    send_item(MODE_PUSH, $urandom(), 3'd0, 1'b0);
    send_item(MODE_POP, $urandom(), 3'($urandom_range(1, 3)), 1'b0);
    space = RING_DEPTH - held_count();
    send_item(MODE_PUSH, $urandom(), 3'(space), 1'($urandom_range(0, 1)));  // exact fit
    send_item(MODE_PUSH, $urandom(), 3'd1, 1'b1);
  endtask

  task automatic test_end_of_stream_drain();
    send_item(MODE_END, $urandom(), 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
    while (held_count() != 0)
      send_item(MODE_POP, $urandom(), 3'(($urandom_range(0, 3) == 0) ? $urandom_range(1, 7)
                : 4), 1'($urandom_range(0, 1)));
    send_item(MODE_POP, 32'h0, 3'd4, 1'b0);          // nothing left after end
    send_item(MODE_PUSH, $urandom(), 3'd3, 1'b1);    // pushes still land after end
    send_item(MODE_POP, 32'h0, 3'd4, 1'b0);          // remainder is emitted
    send_item(MODE_POP, 32'h0, 3'd1, 1'b0);
    test_random_traffic(25, 1'b1);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_cases();
    test_random_traffic(40, 1'b0);
    test_end_of_stream_drain();
    test_fill_to_full();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
